FILE: rtl/pfc_pkg.sv
// ----------------------------------------------------------------------------
// pfc_pkg: shared types, constants and helpers
// Letter codes, square geometry, controller/datapath interface structs.
// ----------------------------------------------------------------------------
`default_nettype none

package pfc_pkg;

  localparam int GRID_SIDE = 5;
  localparam int CELLS     = GRID_SIDE * GRID_SIDE;
  localparam int LETTERS   = 26;

  typedef logic [4:0] letter_t;
  typedef logic [4:0] cell_t;
  typedef logic [2:0] coord_t;

  localparam letter_t LETTER_COUNT = letter_t'(LETTERS);
  localparam letter_t LETTER_LAST  = letter_t'(LETTERS - 1);
  localparam letter_t LETTER_I     = letter_t'(8);
  localparam letter_t LETTER_J     = letter_t'(9);
  localparam letter_t LETTER_X     = letter_t'(23);
  localparam cell_t   CELL_COUNT   = cell_t'(CELLS);

  typedef enum logic [1:0] {
    MODE_CLEAR = 2'd0,
    MODE_KEY   = 2'd1,
    MODE_ENC   = 2'd2,
    MODE_DEC   = 2'd3
  } mode_t;

  // controller -> datapath
  typedef struct packed {
    logic load;         // capture input item
    logic clear;        // empty the square
    logic key_place;    // place the captured key letter
    logic seal_step;    // place one alphabet letter during seal walk
    logic text;         // apply text letter, read cell positions
    logic map;          // compute target cells, read square
    logic emit_second;  // present second letter of the pair
  } pfc_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_clear;
    logic is_bad;
    logic is_key;
    logic sealed;
    logic seal_last;
    logic pair_go;
  } pfc_status_t;

  function automatic coord_t cell_row(cell_t c);
    coord_t r;
    r = '0;
    for (int k = 1; k < GRID_SIDE; k++) begin
      if (c >= cell_t'(k * GRID_SIDE)) r = coord_t'(k);
    end
    return r;
  endfunction

  function automatic cell_t cell_of(coord_t r, coord_t c);
    return cell_t'(r * GRID_SIDE + c);
  endfunction

  function automatic coord_t cell_col(cell_t c);
    return coord_t'(c - cell_of(cell_row(c), '0));
  endfunction

  // one step right/down, or left/up when deciphering, wrapping at the edge
  function automatic coord_t wrap_step(coord_t v, logic dec);
    coord_t r;
    if (dec) r = (v == '0) ? coord_t'(GRID_SIDE - 1) : coord_t'(v - 1'b1);
    else     r = (v == coord_t'(GRID_SIDE - 1)) ? '0 : coord_t'(v + 1'b1);
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/pfc_datapath.sv
// ----------------------------------------------------------------------------
// pfc_datapath: square storage and pair arithmetic
// Holds the captured item, the square and letter-position memories, the
// fill/seal state, the open pair and the repeat-rule letter.
// ----------------------------------------------------------------------------
`default_nettype none

module pfc_datapath (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic [1:0]           mode,
  input  wire pfc_pkg::letter_t     letter,
  input  wire logic                 last,
  input  wire pfc_pkg::pfc_cmd_t    cmd,
  output pfc_pkg::pfc_status_t      status,
  output pfc_pkg::letter_t          out_letter,
  output logic                      out_last
);
  import pfc_pkg::*;

  // captured item
  mode_t   item_mode;
  letter_t item_letter;
  logic    item_last;

  // control state
  logic [LETTERS-1:0] used;
  cell_t              fill_count;
  logic               sealed;
  letter_t            seal_ctr;
  letter_t            held_letter;
  logic               held_valid;
  letter_t            prev_letter;
  logic               prev_valid;

  // memories
  letter_t sq_mem [CELLS];
  cell_t   pos_mem [LETTERS];

  // registered read data
  cell_t   pos_a, pos_b;
  letter_t sq_a, sq_b;
  logic    pair_dec, pair_final;

  letter_t item_norm, place_l, text_l, pair_a, pair_b;
  logic    item_enc, item_dec, place_req, place_en;
  coord_t  ra, xa, rb, xb;
  cell_t   oa, ob;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_mode   <= mode_t'(mode);
      item_letter <= letter;
      item_last   <= last;
    end
  end

  assign item_norm = (item_letter == LETTER_J) ? LETTER_I : item_letter;
  assign item_enc  = (item_mode == MODE_ENC);
  assign item_dec  = (item_mode == MODE_DEC);

  // letter placement, shared by key letters and the alphabet walk
  assign place_l   = cmd.seal_step ? seal_ctr : item_norm;
  assign place_req = cmd.key_place || (cmd.seal_step && seal_ctr != LETTER_J);
  assign place_en  = place_req && !used[place_l] && (fill_count < CELL_COUNT);

  // repeat rule and pair formation
  assign text_l = (item_enc && prev_valid && prev_letter == item_norm) ? LETTER_X
                                                                       : item_norm;
  assign pair_a = held_valid ? held_letter : text_l;
  assign pair_b = held_valid ? text_l : LETTER_X;

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      used        <= '0;
      fill_count  <= '0;
      sealed      <= 1'b0;
      seal_ctr    <= '0;
      held_letter <= '0;
      held_valid  <= 1'b0;
      prev_letter <= '0;
      prev_valid  <= 1'b0;
    end else begin
      if (place_en) begin
        used[place_l] <= 1'b1;
        fill_count    <= fill_count + 1'b1;
      end
      if (cmd.seal_step) begin
        if (seal_ctr == LETTER_LAST) begin
          seal_ctr <= '0;
          sealed   <= 1'b1;
        end else begin
          seal_ctr <= seal_ctr + 1'b1;
        end
      end
      if (cmd.text) begin
        if (item_enc) begin
          prev_letter <= text_l;
          prev_valid  <= 1'b1;
        end
        if (held_valid) begin
          held_valid <= 1'b0;
        end else if (!item_last) begin
          held_letter <= text_l;
          held_valid  <= 1'b1;
        end
        if (item_last) begin
          held_valid <= 1'b0;
          prev_valid <= 1'b0;
        end
      end
    end
  end

  // letter -> cell index memory
  always_ff @(posedge clk) begin
    if (place_en) pos_mem[place_l] <= fill_count;
    if (cmd.text) begin
      pos_a      <= pos_mem[pair_a];
      pos_b      <= pos_mem[pair_b];
      pair_dec   <= item_dec;
      pair_final <= item_last;
    end
  end

  // pair rules on row/column coordinates
  always_comb begin
    ra = cell_row(pos_a);
    xa = cell_col(pos_a);
    rb = cell_row(pos_b);
    xb = cell_col(pos_b);
    if (ra == rb) begin
      oa = cell_of(ra, wrap_step(xa, pair_dec));
      ob = cell_of(rb, wrap_step(xb, pair_dec));
    end else if (xa == xb) begin
      oa = cell_of(wrap_step(ra, pair_dec), xa);
      ob = cell_of(wrap_step(rb, pair_dec), xb);
    end else begin
      oa = cell_of(ra, xb);
      ob = cell_of(rb, xa);
    end
  end

  // cell index -> letter memory
  always_ff @(posedge clk) begin
    if (place_en) sq_mem[fill_count] <= place_l;
    if (cmd.map) begin
      sq_a <= sq_mem[oa];
      sq_b <= sq_mem[ob];
    end
  end

  assign out_letter = cmd.emit_second ? sq_b : sq_a;
  assign out_last   = cmd.emit_second && pair_final;

  assign status.is_clear  = (item_mode == MODE_CLEAR);
  assign status.is_bad    = (item_letter >= LETTER_COUNT);
  assign status.is_key    = (item_mode == MODE_KEY);
  assign status.sealed    = sealed;
  assign status.seal_last = (seal_ctr == LETTER_LAST);
  assign status.pair_go   = held_valid || (item_last && item_enc);

endmodule

`default_nettype wire

FILE: rtl/pfc_ctrl.sv
// ----------------------------------------------------------------------------
// pfc_ctrl: sequencing state machine
// Decodes each item, runs the alphabet walk that seals the square, steps a
// pair through position lookup and square read, then hands out two letters.
// ----------------------------------------------------------------------------
`default_nettype none

module pfc_ctrl (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  input  wire pfc_pkg::pfc_status_t  status,
  output pfc_pkg::pfc_cmd_t          cmd
);
  import pfc_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SEAL,
    S_TEXT,
    S_MAP,
    S_EMIT_A,
    S_EMIT_B
  } state_t;

  state_t state;
  logic   emit_second;
  logic   no_text;

  assign no_text  = status.is_clear || status.is_bad || status.is_key;
  assign in_stall = (state != S_IDLE);

  always_comb begin
    cmd             = '0;
    cmd.load        = in_valid && (state == S_IDLE);
    cmd.clear       = (state == S_DECODE) && status.is_clear;
    cmd.key_place   = (state == S_DECODE) && !status.is_clear && !status.is_bad &&
                      status.is_key && !status.sealed;
    cmd.seal_step   = (state == S_SEAL);
    cmd.text        = (state == S_TEXT);
    cmd.map         = (state == S_MAP);
    cmd.emit_second = emit_second;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      out_valid   <= 1'b0;
      emit_second <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) state <= S_DECODE;
        end
        S_DECODE: begin
          if (no_text)             state <= S_IDLE;
          else if (!status.sealed) state <= S_SEAL;
          else                     state <= S_TEXT;
        end
        S_SEAL: begin
          if (status.seal_last) state <= S_TEXT;
        end
        S_TEXT: begin
          state <= status.pair_go ? S_MAP : S_IDLE;
        end
        S_MAP: begin
          state       <= S_EMIT_A;
          out_valid   <= 1'b1;
          emit_second <= 1'b0;
        end
        S_EMIT_A: begin
          if (!out_stall) begin
            state       <= S_EMIT_B;
            emit_second <= 1'b1;
          end
        end
        S_EMIT_B: begin
          if (!out_stall) begin
            state       <= S_IDLE;
            out_valid   <= 1'b0;
            emit_second <= 1'b0;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: rtl/playfair_digraph_cipher.sv
// Timing: a clear or key item passes through decode only; a text letter that
// opens a pair is also applied in the text step. A letter completing a pair
// presents its first result after the text and map steps, the second in the
// cycle after the first is taken; the input is free again the cycle after the
// second transfer. The first text letter after an unsealed square first walks
// the alphabet. One item in flight at a time; rate set by the sequencer.
// Reset (rst, synchronous) leaves an empty, unsealed square and no open pair.
// ----------------------------------------------------------------------------
// playfair_digraph_cipher: 5x5 digraph substitution engine
// Builds the square from key letters and enciphers or deciphers text pairs.
// ----------------------------------------------------------------------------
`default_nettype none

module playfair_digraph_cipher (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [1:0]        mode,
  input  wire pfc_pkg::letter_t  letter,
  input  wire logic              last,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output pfc_pkg::letter_t       out_letter,
  output logic                   out_last
);
  import pfc_pkg::*;

  pfc_cmd_t    cmd;
  pfc_status_t status;

  pfc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  pfc_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .mode       (mode),
    .letter     (letter),
    .last       (last),
    .cmd        (cmd),
    .status     (status),
    .out_letter (out_letter),
    .out_last   (out_last)
  );

endmodule

`default_nettype wire

FILE: rtl/pfc_checker.sv
// ----------------------------------------------------------------------------
// pfc_checker: port-level checks for the cipher block
// Watches both channels; bound to the top level below.
// ----------------------------------------------------------------------------
`default_nettype none

module pfc_checker (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              in_valid,
  input wire logic              in_stall,
  input wire logic              out_valid,
  input wire logic              out_stall,
  input wire pfc_pkg::letter_t  out_letter,
  input wire logic              out_last
);
  import pfc_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_letter) && $stable(out_last))
    else $error("result changed while stalled");

  // no input transfer while a result is pending
  a_busy_stall: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("input taken while result pending");

  // an accepted item keeps the input stalled while it is worked on
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input not stalled after a transfer");

  // the flagged final letter closes the pair
  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && out_last |=> !out_valid)
    else $error("result after final letter of pair");

  // results come from a sealed square: never j, never past z
  a_letter_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_letter != LETTER_J) && (out_letter < LETTER_COUNT))
    else $error("invalid result letter");

endmodule

bind playfair_digraph_cipher pfc_checker u_pfc_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .out_letter (out_letter),
  .out_last   (out_last)
);

`default_nettype wire
